// ===== rtl/core/websocket_client_frame_parser_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the WebSocket client frame parser
// Clocked concurrent checks, disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_CLIENT_FRAME_PARSER_UNIT_MACROS_SVH
`define WEBSOCKET_CLIENT_FRAME_PARSER_UNIT_MACROS_SVH

// prop must hold at every edge outside reset
`define WSCFP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cond must never be seen outside reset
`define WSCFP_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/wscfp_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket client frame parser package
// Shared types and constants: parse phases, frame status codes, result item.
// ----------------------------------------------------------------------------
package wscfp_pkg;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXTLEN,
        PH_MASK,
        PH_DATA
    } t_phase;

    typedef enum logic [1:0] {
        ST_DATA  = 2'd0,
        ST_CLOSE = 2'd1,
        ST_SKIP  = 2'd2,
        ST_ERROR = 2'd3
    } t_status;

    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    // extended length and mask key byte counts, minus one
    localparam logic [2:0] EXT16_LEFT = 3'd1;
    localparam logic [2:0] EXT64_LEFT = 3'd7;
    localparam logic [2:0] MASK_LEFT  = 3'd3;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        payload_last;
        logic        frame_done;
        t_status     frame_status;
        logic [3:0]  frame_opcode;
        logic [63:0] frame_length;
    } t_result;

endpackage

// ===== rtl/core/wscfp_in_if.sv =====
// ----------------------------------------------------------------------------
// Input byte channel
// Valid/ready channel carrying one raw stream byte per item.
// ----------------------------------------------------------------------------
interface wscfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== rtl/core/wscfp_out_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying payload bytes and frame status items.
// ----------------------------------------------------------------------------
interface wscfp_out_if;
    logic        valid;
    logic        ready;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic        frame_done;
    logic [1:0]  frame_status;
    logic [3:0]  frame_opcode;
    logic [63:0] frame_length;

    modport source (
        output valid, output payload_valid, output payload_byte, output payload_last,
        output frame_done, output frame_status, output frame_opcode, output frame_length,
        input ready
    );
    modport sink (
        input valid, input payload_valid, input payload_byte, input payload_last,
        input frame_done, input frame_status, input frame_opcode, input frame_length,
        output ready
    );
endinterface

// ===== rtl/core/wscfp_in_reg.sv =====
// ----------------------------------------------------------------------------
// Input register
// Holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module wscfp_in_reg (
    input  logic         i_clk,
    input  logic         i_rst_n,
    wscfp_in_if.sink     i_in,
    input  logic         i_take,
    output logic         o_valid,
    output logic [7:0]   o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       n_valid;
    logic       w_load;

    assign i_in.ready = !r_valid || i_take;
    assign w_load     = i_in.valid && i_in.ready;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_in.in_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ===== rtl/core/wscfp_parser.sv =====
// ----------------------------------------------------------------------------
// Frame parser
// Header decode, length and mask key capture, payload unmasking per byte.
// ----------------------------------------------------------------------------
`include "websocket_client_frame_parser_unit_macros.svh"

module wscfp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    output logic              o_has_result,
    output wscfp_pkg::t_result o_result
);

    wscfp_pkg::t_phase r_phase,  n_phase;
    logic              r_final,  n_final;
    logic [3:0]        r_opcode, n_opcode;
    logic [63:0]       r_len,    n_len;
    logic [63:0]       r_remain, n_remain;
    logic [2:0]        r_count,  n_count;
    logic [31:0]       r_key,    n_key;
    logic [1:0]        r_mpos,   n_mpos;
    logic              r_deliver, n_deliver;
    logic              r_halt,   n_halt;

    wscfp_pkg::t_status w_status;
    logic [7:0]         w_key_byte;
    logic [7:0]         w_plain;
    logic               w_last;
    logic [6:0]         w_code;

    always_comb begin
        if (r_opcode == wscfp_pkg::OP_CLOSE) begin
            w_status = wscfp_pkg::ST_CLOSE;
        end else if (r_final && (r_opcode == wscfp_pkg::OP_TEXT ||
                                 r_opcode == wscfp_pkg::OP_BINARY)) begin
            w_status = wscfp_pkg::ST_DATA;
        end else begin
            w_status = wscfp_pkg::ST_SKIP;
        end
    end

    // key bytes are used most significant first
    always_comb begin
        unique case (r_mpos)
            2'd0:    w_key_byte = r_key[31:24];
            2'd1:    w_key_byte = r_key[23:16];
            2'd2:    w_key_byte = r_key[15:8];
            default: w_key_byte = r_key[7:0];
        endcase
    end

    assign w_plain = i_byte ^ w_key_byte;
    assign w_last  = (r_remain[63:1] == 63'd0);
    assign w_code  = i_byte[6:0];

    always_comb begin
        n_phase   = r_phase;
        n_final   = r_final;
        n_opcode  = r_opcode;
        n_len     = r_len;
        n_remain  = r_remain;
        n_count   = r_count;
        n_key     = r_key;
        n_mpos    = r_mpos;
        n_deliver = r_deliver;
        n_halt    = r_halt;
        o_has_result = 1'b0;
        o_result     = '0;

        if (i_step && !r_halt) begin
            unique case (r_phase)
                wscfp_pkg::PH_HDR0: begin
                    n_final  = i_byte[7];
                    n_opcode = i_byte[3:0];
                    n_phase  = wscfp_pkg::PH_HDR1;
                end
                wscfp_pkg::PH_HDR1: begin
                    if (!i_byte[7]) begin
                        // unmasked client frame: report and stop
                        n_halt  = 1'b1;
                        n_phase = wscfp_pkg::PH_HDR0;
                        o_has_result          = 1'b1;
                        o_result.frame_done   = 1'b1;
                        o_result.frame_status = wscfp_pkg::ST_ERROR;
                        o_result.frame_opcode = r_opcode;
                    end else if (w_code == wscfp_pkg::LEN_CODE_16) begin
                        n_len   = '0;
                        n_count = wscfp_pkg::EXT16_LEFT;
                        n_phase = wscfp_pkg::PH_EXTLEN;
                    end else if (w_code == wscfp_pkg::LEN_CODE_64) begin
                        n_len   = '0;
                        n_count = wscfp_pkg::EXT64_LEFT;
                        n_phase = wscfp_pkg::PH_EXTLEN;
                    end else begin
                        n_len   = {57'd0, w_code};
                        n_count = wscfp_pkg::MASK_LEFT;
                        n_key   = '0;
                        n_phase = wscfp_pkg::PH_MASK;
                    end
                end
                wscfp_pkg::PH_EXTLEN: begin
                    n_len = {r_len[55:0], i_byte};
                    if (r_count == 3'd0) begin
                        n_count = wscfp_pkg::MASK_LEFT;
                        n_key   = '0;
                        n_phase = wscfp_pkg::PH_MASK;
                    end else begin
                        n_count = r_count - 3'd1;
                    end
                end
                wscfp_pkg::PH_MASK: begin
                    n_key = {r_key[23:0], i_byte};
                    if (r_count != 3'd0) begin
                        n_count = r_count - 3'd1;
                    end else begin
                        n_deliver = (w_status == wscfp_pkg::ST_DATA);
                        n_mpos    = 2'd0;
                        n_remain  = r_len;
                        if (r_len == 64'd0) begin
                            n_phase = wscfp_pkg::PH_HDR0;
                            o_has_result          = 1'b1;
                            o_result.frame_done   = 1'b1;
                            o_result.frame_status = w_status;
                            o_result.frame_opcode = r_opcode;
                        end else begin
                            n_phase = wscfp_pkg::PH_DATA;
                        end
                    end
                end
                wscfp_pkg::PH_DATA: begin
                    n_mpos   = r_mpos + 2'd1;
                    n_remain = w_last ? 64'd0 : r_remain - 64'd1;
                    if (w_last) begin
                        n_phase = wscfp_pkg::PH_HDR0;
                        o_has_result          = 1'b1;
                        o_result.frame_done   = 1'b1;
                        o_result.frame_opcode = r_opcode;
                        o_result.frame_length = r_len;
                        if (r_deliver) begin
                            o_result.payload_valid = 1'b1;
                            o_result.payload_byte  = w_plain;
                            o_result.payload_last  = 1'b1;
                            o_result.frame_status  = wscfp_pkg::ST_DATA;
                        end else begin
                            o_result.frame_status  = w_status;
                        end
                    end else if (r_deliver) begin
                        o_has_result           = 1'b1;
                        o_result.payload_valid = 1'b1;
                        o_result.payload_byte  = w_plain;
                    end
                end
                default: begin
                    n_phase = wscfp_pkg::PH_HDR0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= wscfp_pkg::PH_HDR0;
            r_final   <= 1'b0;
            r_opcode  <= '0;
            r_len     <= '0;
            r_remain  <= '0;
            r_count   <= '0;
            r_key     <= '0;
            r_mpos    <= '0;
            r_deliver <= 1'b0;
            r_halt    <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_final   <= n_final;
            r_opcode  <= n_opcode;
            r_len     <= n_len;
            r_remain  <= n_remain;
            r_count   <= n_count;
            r_key     <= n_key;
            r_mpos    <= n_mpos;
            r_deliver <= n_deliver;
            r_halt    <= n_halt;
        end
    end

    `WSCFP_ASSERT(a_halt_sticks, i_clk, i_rst_n, r_halt |=> r_halt, "halt flag dropped")
    `WSCFP_ASSERT(a_error_halts, i_clk, i_rst_n,
        (o_has_result && o_result.frame_status == wscfp_pkg::ST_ERROR) |=> r_halt,
        "error status without halt")
    `WSCFP_ASSERT_NEVER(a_halt_silent, i_clk, i_rst_n, r_halt && o_has_result,
        "result produced while halted")
    `WSCFP_ASSERT_NEVER(a_data_nonempty, i_clk, i_rst_n,
        r_phase == wscfp_pkg::PH_DATA && r_remain == 64'd0,
        "payload phase with nothing left")
    `WSCFP_ASSERT_NEVER(a_payload_gated, i_clk, i_rst_n,
        o_result.payload_valid && !r_deliver, "payload from a dropped frame")

endmodule

// ===== rtl/core/wscfp_out_reg.sv =====
// ----------------------------------------------------------------------------
// Result register
// Holds one result item for the receiver; frees itself as it is taken.
// ----------------------------------------------------------------------------
module wscfp_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  wscfp_pkg::t_result i_result,
    output logic               o_space,
    wscfp_out_if.source        o_out
);

    logic               r_valid;
    logic               n_valid;
    wscfp_pkg::t_result r_data;

    assign o_space = !r_valid || o_out.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_result;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.payload_valid = r_data.payload_valid;
    assign o_out.payload_byte  = r_data.payload_byte;
    assign o_out.payload_last  = r_data.payload_last;
    assign o_out.frame_done    = r_data.frame_done;
    assign o_out.frame_status  = r_data.frame_status;
    assign o_out.frame_opcode  = r_data.frame_opcode;
    assign o_out.frame_length  = r_data.frame_length;

endmodule

// ===== rtl/core/websocket_client_frame_parser_unit.sv =====
// ----------------------------------------------------------------------------
// WebSocket client frame parser
// Parses a client-to-server frame stream one byte per item and unmasks payload.
// ----------------------------------------------------------------------------
// i_frame carries one raw stream byte per item. o_result carries at most one
// item per input byte: an unmasked payload byte of a final text or binary
// frame, and/or the frame status (frame_done) that closes every frame.
// Header, length and mask-key bytes produce no item but the status of an
// unmasked or empty frame; undelivered payload bytes but the last give none.
// Items pass the input register, parser and result register. Throughput: one
// byte per cycle unless the receiver stalls; each byte is a single header step
// or one XOR plus the 64-bit remaining-count decrement, all in one register
// stage. On a stall the result register holds its item and the input register
// takes one more byte; then i_frame.ready drops until o_result moves.
// Reset clears all parse state; the parser waits for the first header byte.
// An unmasked frame yields an error status, after which every byte is
// accepted and discarded until the next reset.
// ----------------------------------------------------------------------------
module websocket_client_frame_parser_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    wscfp_in_if.sink     i_frame,
    wscfp_out_if.source  o_result
);

    logic               w_in_valid;
    logic [7:0]         w_in_byte;
    logic               w_space;
    logic               w_step;
    logic               w_has_result;
    wscfp_pkg::t_result w_result;

    assign w_step = w_in_valid && w_space;

    wscfp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_frame),
        .i_take  (w_step),
        .o_valid (w_in_valid),
        .o_byte  (w_in_byte)
    );

    wscfp_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_byte       (w_in_byte),
        .o_has_result (w_has_result),
        .o_result     (w_result)
    );

    wscfp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_has_result),
        .i_result (w_result),
        .o_space  (w_space),
        .o_out    (o_result)
    );

endmodule
